// ===== rtl/core/bdgl_pkg.sv =====
package bdgl_pkg;

  // Item kinds carried on the input channel
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // Configuration register indexes
  localparam int unsigned CFG_IW = 3;
  typedef enum logic [CFG_IW-1:0] {
    REG_ORIGIN_X      = 3'd0,
    REG_ORIGIN_Y      = 3'd1,
    REG_INV_CELL_SIZE = 3'd2,
    REG_GRID_COLS     = 3'd3,
    REG_GRID_ROWS     = 3'd4,
    REG_MAP_VALID     = 3'd5
  } cfg_reg_e;

  // Reset values of the configuration registers
  localparam logic [31:0] INV_CELL_SIZE_RST = 32'd1310720;
  localparam logic [8:0]  GRID_DIM_RST      = 9'd256;

endpackage

// ===== rtl/core/bdgl_intf.sv =====
interface bdgl_in_if;
  logic              valid;
  logic              ready;
  bdgl_pkg::op_e     operation;
  logic [15:0]       cell_index;
  logic [15:0]       cell_value;
  logic signed [31:0] query_x;
  logic signed [31:0] query_y;
  modport source (output valid, operation, cell_index, cell_value, query_x, query_y,
                  input ready);
  modport sink   (input valid, operation, cell_index, cell_value, query_x, query_y,
                  output ready);
endinterface

interface bdgl_out_if;
  logic               valid;
  logic               ready;
  logic               inside_res;
  logic [15:0]        distance;
  logic signed [31:0] grad_x;
  logic signed [31:0] grad_y;
  modport source (output valid, inside_res, distance, grad_x, grad_y, input ready);
  modport sink   (input valid, inside_res, distance, grad_x, grad_y, output ready);
endinterface

interface bdgl_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [bdgl_pkg::CFG_IW-1:0] index;
  logic [31:0]                 data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/bdgl_ram.sv =====
module bdgl_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one word, read one word into the output register
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/bilinear_distance_gradient_lookup.sv =====
// Bilinear distance lookup with gradient. Write beats store one Q8.8 distance into the
// grid at cell_index; query beats map a Q16.16 world position to the grid and return the
// interpolated distance and its saturated Q16.16 x and y gradients, or a zeroed result
// with inside_res low when no map is loaded or the 2x2 neighbourhood leaves the grid.
// One beat is accepted per cycle unless a stall on the result channel holds the pipeline; a
// query result passes through an eleven-stage pipeline (subtract, magnitude, coordinate
// multiply, range check, address multiply, grid read, differences, x blend, y blend,
// gradient multiply, rounding). The grid is held as four copies, one per neighbour, so
// all four reads share a cycle; writes pass through the same pipeline and so keep their
// order with queries. A write beat yields no result. Write configuration only while the
// block is idle.
module bilinear_distance_gradient_lookup #(
  parameter int unsigned MAX_COLS = 256,
  parameter int unsigned MAX_ROWS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bdgl_cfg_if.sink    cfg_i,
  bdgl_in_if.sink     in_i,
  bdgl_out_if.source  out_o
);

  localparam int unsigned XW    = $clog2(MAX_COLS);
  localparam int unsigned YW    = $clog2(MAX_ROWS);
  localparam int unsigned CW    = $clog2(MAX_COLS + 1);
  localparam int unsigned RW    = $clog2(MAX_ROWS + 1);
  localparam int unsigned DEPTH = MAX_COLS * MAX_ROWS;
  localparam int unsigned AW    = $clog2(DEPTH);

  // Configuration registers
  logic signed [31:0] ox_q, oy_q;
  logic [31:0]        inv_q;
  logic [8:0]         cols_q, rows_q;
  logic               mapv_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ox_q   <= '0;
      oy_q   <= '0;
      inv_q  <= bdgl_pkg::INV_CELL_SIZE_RST;
      cols_q <= bdgl_pkg::GRID_DIM_RST;
      rows_q <= bdgl_pkg::GRID_DIM_RST;
      mapv_q <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        bdgl_pkg::REG_ORIGIN_X:      ox_q   <= cfg_i.data;
        bdgl_pkg::REG_ORIGIN_Y:      oy_q   <= cfg_i.data;
        bdgl_pkg::REG_INV_CELL_SIZE: inv_q  <= cfg_i.data;
        bdgl_pkg::REG_GRID_COLS:     cols_q <= cfg_i.data[8:0];
        bdgl_pkg::REG_GRID_ROWS:     rows_q <= cfg_i.data[8:0];
        bdgl_pkg::REG_MAP_VALID:     mapv_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Clamp grid size in use to the storage
  logic [CW-1:0] cols_eff;
  logic [RW-1:0] rows_eff;
  assign cols_eff = (32'(cols_q) < 32'(MAX_COLS)) ? CW'(cols_q) : CW'(MAX_COLS);
  assign rows_eff = (32'(rows_q) < 32'(MAX_ROWS)) ? RW'(rows_q) : RW'(MAX_ROWS);

  // Per-stage valid bits and advance enables
  localparam int unsigned NS = 11;
  logic [NS-1:0] v_q;
  logic [NS-1:0] en;
  logic [NS-1:0] vin;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || out_o.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_i.ready = en[0];

  // Stage 1: offsets from origin
  bdgl_pkg::op_e      op1_q;
  logic [15:0]        ci1_q, cv1_q;
  logic signed [32:0] dx1_q, dy1_q;
  // Stage 2: magnitudes
  bdgl_pkg::op_e      op2_q;
  logic [15:0]        ci2_q, cv2_q;
  logic               nx2_q, ny2_q;
  logic [31:0]        mx2_q, my2_q;
  // Stage 3: grid coordinates
  bdgl_pkg::op_e      op3_q;
  logic [15:0]        ci3_q, cv3_q;
  logic               nx3_q, ny3_q;
  logic [63:0]        px3_q, py3_q;
  // Stage 4: cell and weights
  bdgl_pkg::op_e      op4_q;
  logic [15:0]        ci4_q, cv4_q;
  logic               in4_q;
  logic [XW-1:0]      x04_q;
  logic [YW-1:0]      y04_q;
  logic [15:0]        tx4_q, ty4_q;
  // Stage 5: linear address
  bdgl_pkg::op_e      op5_q;
  logic [15:0]        ci5_q, cv5_q;
  logic               in5_q;
  logic [AW-1:0]      a5_q;
  logic [15:0]        tx5_q, ty5_q;
  // Stage 6: grid data
  logic               in6_q;
  logic [15:0]        tx6_q, ty6_q;
  logic [15:0]        d00, d10, d01, d11;
  // Stage 7: differences
  logic               in7_q;
  logic [15:0]        tx7_q, ty7_q;
  logic [15:0]        d007_q, d107_q, d017_q, d117_q;
  logic signed [16:0] ax7_q, bx7_q, ay7_q, by7_q;
  // Stage 8: x blend and gradient sums
  logic               in8_q;
  logic [15:0]        ty8_q;
  logic [31:0]        e08_q, e18_q;
  logic signed [35:0] sgx8_q, sgy8_q;
  // Stage 9: y blend products and gradient magnitudes
  logic               in9_q;
  logic [47:0]        pe09_q, pe19_q;
  logic               ngx9_q, ngy9_q;
  logic [31:0]        mgx9_q, mgy9_q;
  // Stage 10: rounded distance and scaled gradients
  logic               in10_q;
  logic [15:0]        dist10_q;
  logic               ngx10_q, ngy10_q;
  logic [63:0]        pgx10_q, pgy10_q;
  // Stage 11: output register
  logic               in11_q;
  logic [15:0]        dist11_q;
  logic signed [31:0] gx11_q, gy11_q;

  // Valid chain; write beats leave after the grid stage
  always_comb begin
    vin[0] = in_i.valid;
    for (int k = 1; k < NS; k++) begin
      vin[k] = v_q[k-1];
    end
    vin[5] = v_q[4] && (op5_q == bdgl_pkg::OP_QUERY);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= vin[k];
        end
      end
    end
  end

  // Stage 4 range checks
  logic [31:0] ix, iy;
  logic        okx, oky;
  assign ix  = px3_q[63:32];
  assign iy  = py3_q[63:32];
  assign okx = !(nx3_q && (px3_q != '0)) && ((33'(ix) + 33'd1) < 33'(cols_eff));
  assign oky = !(ny3_q && (py3_q != '0)) && ((33'(iy) + 33'd1) < 33'(rows_eff));

  // Stage 6 grid access
  logic          we;
  logic          re;
  logic [AW-1:0] waddr;
  assign we    = en[5] && v_q[4] && (op5_q == bdgl_pkg::OP_WRITE) &&
                 (32'(ci5_q) < 32'(DEPTH));
  assign re    = en[5] && v_q[4] && (op5_q == bdgl_pkg::OP_QUERY);
  assign waddr = AW'(32'(ci5_q));

  bdgl_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram00 (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(cv5_q),
    .re_i(re), .raddr_i(a5_q), .rdata_o(d00)
  );
  bdgl_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram10 (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(cv5_q),
    .re_i(re), .raddr_i(a5_q + AW'(1)), .rdata_o(d10)
  );
  bdgl_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram01 (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(cv5_q),
    .re_i(re), .raddr_i(a5_q + AW'(cols_eff)), .rdata_o(d01)
  );
  bdgl_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram11 (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(cv5_q),
    .re_i(re), .raddr_i(a5_q + AW'(cols_eff) + AW'(1)), .rdata_o(d11)
  );

  // Weights for stage 8 and 9
  logic [16:0]        wx0, wx1, wy0, wy1, wy08, wy18;
  logic signed [17:0] wx0s, wx1s, wy0s, wy1s;
  assign wx1  = {1'b0, tx7_q};
  assign wx0  = 17'h10000 - wx1;
  assign wy1  = {1'b0, ty7_q};
  assign wy0  = 17'h10000 - wy1;
  assign wx0s = $signed({1'b0, wx0});
  assign wx1s = $signed({1'b0, wx1});
  assign wy0s = $signed({1'b0, wy0});
  assign wy1s = $signed({1'b0, wy1});
  assign wy18 = {1'b0, ty8_q};
  assign wy08 = 17'h10000 - wy18;

  // Stage 10 inputs
  logic [47:0] sum10;
  assign sum10 = pe09_q + pe19_q + 48'h0000_8000_0000;

  // Stage 11 rounding and saturation
  logic [63:0] rgx, rgy;
  logic [31:0] gx_sat, gy_sat;
  assign rgx = (pgx10_q + 64'h80_0000) >> 24;
  assign rgy = (pgy10_q + 64'h80_0000) >> 24;

  always_comb begin
    if (ngx10_q) begin
      gx_sat = (rgx >= 64'h8000_0000) ? 32'h8000_0000 : 32'(0) - rgx[31:0];
    end else begin
      gx_sat = (rgx > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : rgx[31:0];
    end
    if (ngy10_q) begin
      gy_sat = (rgy >= 64'h8000_0000) ? 32'h8000_0000 : 32'(0) - rgy[31:0];
    end else begin
      gy_sat = (rgy > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : rgy[31:0];
    end
  end

  // Advance payload registers
  logic signed [32:0] absx, absy;
  assign absx = (dx1_q < 0) ? -dx1_q : dx1_q;
  assign absy = (dy1_q < 0) ? -dy1_q : dy1_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      op1_q <= in_i.operation;
      ci1_q <= in_i.cell_index;
      cv1_q <= in_i.cell_value;
      dx1_q <= 33'(in_i.query_x) - 33'(ox_q);
      dy1_q <= 33'(in_i.query_y) - 33'(oy_q);
    end
    if (en[1]) begin
      op2_q <= op1_q;
      ci2_q <= ci1_q;
      cv2_q <= cv1_q;
      nx2_q <= dx1_q < 0;
      ny2_q <= dy1_q < 0;
      mx2_q <= absx[31:0];
      my2_q <= absy[31:0];
    end
    if (en[2]) begin
      op3_q <= op2_q;
      ci3_q <= ci2_q;
      cv3_q <= cv2_q;
      nx3_q <= nx2_q;
      ny3_q <= ny2_q;
      px3_q <= 64'(mx2_q) * 64'(inv_q);
      py3_q <= 64'(my2_q) * 64'(inv_q);
    end
    if (en[3]) begin
      op4_q <= op3_q;
      ci4_q <= ci3_q;
      cv4_q <= cv3_q;
      in4_q <= mapv_q && okx && oky;
      x04_q <= ix[XW-1:0];
      y04_q <= iy[YW-1:0];
      tx4_q <= px3_q[31:16];
      ty4_q <= py3_q[31:16];
    end
    if (en[4]) begin
      op5_q <= op4_q;
      ci5_q <= ci4_q;
      cv5_q <= cv4_q;
      in5_q <= in4_q;
      a5_q  <= AW'(32'(y04_q) * 32'(cols_eff) + 32'(x04_q));
      tx5_q <= tx4_q;
      ty5_q <= ty4_q;
    end
    if (en[5]) begin
      in6_q <= in5_q;
      tx6_q <= tx5_q;
      ty6_q <= ty5_q;
    end
    if (en[6]) begin
      in7_q  <= in6_q;
      tx7_q  <= tx6_q;
      ty7_q  <= ty6_q;
      d007_q <= d00;
      d107_q <= d10;
      d017_q <= d01;
      d117_q <= d11;
      ax7_q  <= $signed({1'b0, d10}) - $signed({1'b0, d00});
      bx7_q  <= $signed({1'b0, d11}) - $signed({1'b0, d01});
      ay7_q  <= $signed({1'b0, d01}) - $signed({1'b0, d00});
      by7_q  <= $signed({1'b0, d11}) - $signed({1'b0, d10});
    end
    if (en[7]) begin
      in8_q  <= in7_q;
      ty8_q  <= ty7_q;
      e08_q  <= 32'(d007_q) * 32'(wx0) + 32'(d107_q) * 32'(wx1);
      e18_q  <= 32'(d017_q) * 32'(wx0) + 32'(d117_q) * 32'(wx1);
      sgx8_q <= ax7_q * wy0s + bx7_q * wy1s;
      sgy8_q <= ay7_q * wx0s + by7_q * wx1s;
    end
    if (en[8]) begin
      in9_q  <= in8_q;
      pe09_q <= 48'(e08_q) * 48'(wy08);
      pe19_q <= 48'(e18_q) * 48'(wy18);
      ngx9_q <= sgx8_q < 0;
      ngy9_q <= sgy8_q < 0;
      mgx9_q <= (sgx8_q < 0) ? 32'(-sgx8_q) : 32'(sgx8_q);
      mgy9_q <= (sgy8_q < 0) ? 32'(-sgy8_q) : 32'(sgy8_q);
    end
    if (en[9]) begin
      in10_q   <= in9_q;
      dist10_q <= sum10[47:32];
      ngx10_q  <= ngx9_q;
      ngy10_q  <= ngy9_q;
      pgx10_q  <= 64'(mgx9_q) * 64'(inv_q);
      pgy10_q  <= 64'(mgy9_q) * 64'(inv_q);
    end
    if (en[10]) begin
      in11_q   <= in10_q;
      dist11_q <= in10_q ? dist10_q : '0;
      gx11_q   <= in10_q ? gx_sat : '0;
      gy11_q   <= in10_q ? gy_sat : '0;
    end
  end

  // Drive the result channel
  assign out_o.valid      = v_q[NS-1];
  assign out_o.inside_res = in11_q;
  assign out_o.distance   = dist11_q;
  assign out_o.grad_x     = gx11_q;
  assign out_o.grad_y     = gy11_q;

endmodule

// ===== tb/bdgl_checker.sv =====
module bdgl_checker #(
  parameter int unsigned MAX_COLS = 256,
  parameter int unsigned MAX_ROWS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bdgl_cfg_if         cfg_mon,
  bdgl_in_if          in_mon,
  bdgl_out_if         out_mon,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o
);

  import bdgl_pkg::*;

  typedef struct packed {
    logic               hit;
    logic [15:0]        dval;
    logic signed [31:0] gx;
    logic signed [31:0] gy;
  } lookup_res_t;

  // Own copy of the grid and the registers
  logic [15:0]        dist_mem [0:MAX_COLS*MAX_ROWS-1];
  logic signed [31:0] org_x_r, org_y_r;
  logic [31:0]        inv_r;
  logic [8:0]         cols_r, rows_r;
  logic               map_ok_r;
  lookup_res_t        lookup_q [$];

  // Map one axis to a cell index and Q0.16 weight; 0 if the 2x2 block leaves the grid
  function automatic logic axis_to_cell(logic signed [31:0] pos, logic signed [31:0] org,
                                        int unsigned lim, output int unsigned idx,
                                        output logic [15:0] frac);
    longint     diff;
    logic [63:0] mag, prod;
    logic       neg;
    diff = longint'(pos) - longint'(org);
    neg  = diff < 0;
    mag  = neg ? 64'(-diff) : 64'(diff);
    prod = mag * {32'b0, inv_r};
    idx  = 0;
    frac = '0;
    if (neg && prod != 0) return 1'b0;
    if ((prod >> 32) + 64'd1 >= 64'(lim)) return 1'b0;
    idx  = prod[63:32];
    frac = prod[31:16];
    return 1'b1;
  endfunction

  // Blend two differences by the cross weight, scale to Q16.16, round and saturate
  function automatic logic signed [31:0] slope(longint a, longint b, logic [15:0] t);
    longint      s;
    logic [63:0] mag, r;
    logic        neg;
    s   = a * (65536 - longint'(t)) + b * longint'(t);
    neg = s < 0;
    mag = neg ? 64'(-s) : 64'(s);
    r   = (mag * {32'b0, inv_r} + (64'd1 << 23)) >> 24;
    if (neg) return (r >= 64'h8000_0000) ? 32'sh8000_0000 : -$signed(r[31:0]);
    return (r > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(r[31:0]);
  endfunction

  function automatic lookup_res_t lookup(logic signed [31:0] qx, logic signed [31:0] qy);
    lookup_res_t res;
    int unsigned cols, rows, x0, y0, a;
    logic [15:0] tx, ty;
    longint      d00, d10, d01, d11;
    logic [63:0] wx0, wx1, wy0, wy1, sum;
    res  = '0;
    cols = (cols_r < MAX_COLS) ? cols_r : MAX_COLS;
    rows = (rows_r < MAX_ROWS) ? rows_r : MAX_ROWS;
    if (!map_ok_r) return res;
    if (!axis_to_cell(qx, org_x_r, cols, x0, tx)) return res;
    if (!axis_to_cell(qy, org_y_r, rows, y0, ty)) return res;
    a   = y0 * cols + x0;
    d00 = dist_mem[a];
    d10 = dist_mem[a + 1];
    d01 = dist_mem[a + cols];
    d11 = dist_mem[a + cols + 1];
    wx1 = tx;
    wx0 = 64'd65536 - tx;
    wy1 = ty;
    wy0 = 64'd65536 - ty;
    sum = 64'(d00) * wx0 * wy0 + 64'(d10) * wx1 * wy0
        + 64'(d01) * wx0 * wy1 + 64'(d11) * wx1 * wy1;
    res.hit  = 1'b1;
    res.dval = 16'((sum + (64'd1 << 31)) >> 32);
    res.gx   = slope(d10 - d00, d11 - d01, ty);
    res.gy   = slope(d01 - d00, d11 - d10, tx);
    return res;
  endfunction

  // Track registers, predict on input beats, compare on output beats
  always @(posedge clk_i or negedge rst_ni) begin
    lookup_res_t want, got;
    if (!rst_ni) begin
      org_x_r    <= '0;
      org_y_r    <= '0;
      inv_r      <= INV_CELL_SIZE_RST;
      cols_r     <= GRID_DIM_RST;
      rows_r     <= GRID_DIM_RST;
      map_ok_r   <= 1'b0;
      lookup_q.delete();
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.inside_res, out_mon.distance, out_mon.grad_x, out_mon.grad_y};
        if (lookup_q.size() == 0) begin
          if (fail_cnt_o < 10) $display("unexpected result beat: %p", got);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          want = lookup_q.pop_front();
          if (got !== want) begin
            if (fail_cnt_o < 10)
              $display("result mismatch: expected %p, got %p", want, got);
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.operation == OP_WRITE) begin
          if (in_mon.cell_index < MAX_COLS * MAX_ROWS)
            dist_mem[in_mon.cell_index] = in_mon.cell_value;
        end else begin
          lookup_q.push_back(lookup(in_mon.query_x, in_mon.query_y));
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_reg_e'(cfg_mon.index))
          REG_ORIGIN_X:      org_x_r  <= cfg_mon.data;
          REG_ORIGIN_Y:      org_y_r  <= cfg_mon.data;
          REG_INV_CELL_SIZE: inv_r    <= cfg_mon.data;
          REG_GRID_COLS:     cols_r   <= cfg_mon.data[8:0];
          REG_GRID_ROWS:     rows_r   <= cfg_mon.data[8:0];
          REG_MAP_VALID:     map_ok_r <= cfg_mon.data[0];
          default: ;
        endcase
      end
      pending_o <= lookup_q.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
module testbench;

  import bdgl_pkg::*;

  localparam logic [CFG_IW-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IW-1:0] REG_SPARE_7 = 3'd7;
  localparam int unsigned       FILL_CELLS  = 256;

  logic        clk_i;
  logic        rst_ni;
  logic        quiet;
  int unsigned fail_cnt, pending;

  // Settings mirrored for shaping queries towards the grid
  logic signed [31:0] cur_ox, cur_oy;
  logic [31:0]        cur_inv;
  int unsigned        cur_cols, cur_rows;

  bdgl_cfg_if cfg_if ();
  bdgl_in_if  in_if ();
  bdgl_out_if out_if ();

  bilinear_distance_gradient_lookup i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  bdgl_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_mon    (cfg_if),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Random back-pressure on the result side
  always @(posedge clk_i) begin
    out_if.ready <= quiet || ($urandom_range(0, 99) >= 30);
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Send one input beat, with an occasional idle gap ahead of it
  task automatic send_beat(op_e op, logic [15:0] idx, logic [15:0] val,
                           logic signed [31:0] qx, logic signed [31:0] qy);
    if (!quiet && $urandom_range(0, 99) < 30) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.operation  <= op;
    in_if.cell_index <= idx;
    in_if.cell_value <= val;
    in_if.query_x    <= qx;
    in_if.query_y    <= qy;
    do @(negedge clk_i); while (!in_if.ready);
    @(posedge clk_i);
  endtask

  task automatic write_cell(logic [15:0] idx, logic [15:0] val);
    send_beat(OP_WRITE, idx, val, $urandom, $urandom);
  endtask

  task automatic query(logic signed [31:0] qx, logic signed [31:0] qy);
    send_beat(OP_QUERY, 16'($urandom), 16'($urandom), qx, qy);
  endtask

  // Drop valid and wait until every result is in, then let the pipeline empty
  task automatic settle();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (15) @(posedge clk_i);
  endtask

  // Hold one register beat until taken; the caller drops valid after the last one
  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [31:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(negedge clk_i); while (!cfg_if.ready);
    @(posedge clk_i);
  endtask

  // Load a full setting; a grid in use with a valid map never exceeds the filled cells
  task automatic apply_setting(logic signed [31:0] ox, logic signed [31:0] oy,
                               logic [31:0] inv, logic [8:0] cols, logic [8:0] rows,
                               logic ok);
    settle();
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_INV_CELL_SIZE, inv);
    write_reg(REG_GRID_COLS, {23'($urandom_range(0, 8388607)), cols});
    write_reg(REG_GRID_ROWS, {23'($urandom_range(0, 8388607)), rows});
    write_reg(REG_MAP_VALID, {31'($urandom), ok});
    cfg_if.valid <= 1'b0;
    cur_ox   = ox;
    cur_oy   = oy;
    cur_inv  = inv;
    cur_cols = (cols > 256) ? 256 : cols;
    cur_rows = (rows > 256) ? 256 : rows;
  endtask

  // Position on one axis, mostly spread over the grid in use
  function automatic logic signed [31:0] near_pos(logic signed [31:0] org, int unsigned n);
    logic [63:0] span;
    logic [63:0] off;
    if ($urandom_range(0, 99) < 20 || cur_inv == 0) return $urandom;
    span = ((64'(n) + 1) << 32) / cur_inv;
    if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
    off = {$urandom, $urandom} % (span + 1);
    return org + 32'(off) - 32'(span >> 3);
  endfunction

  task automatic random_items(int unsigned n);
    for (int unsigned k = 0; k < n; k++) begin
      case ($urandom_range(0, 7))
        0:       write_cell(16'($urandom_range(0, FILL_CELLS - 1)), 16'($urandom));
        1:       write_cell(16'($urandom), 16'($urandom));
        default: query(near_pos(cur_ox, cur_cols), near_pos(cur_oy, cur_rows));
      endcase
    end
  endtask

  initial begin
    quiet            = 1'b0;
    rst_ni           = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = '0;
    cfg_if.data      = '0;
    in_if.valid      = 1'b0;
    in_if.operation  = OP_WRITE;
    in_if.cell_index = '0;
    in_if.cell_value = '0;
    in_if.query_x    = '0;
    in_if.query_y    = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill every cell that a permitted grid can reach
    for (int unsigned c = 0; c < FILL_CELLS; c++) write_cell(16'(c), 16'($urandom));

    // No map loaded yet: all invalid
    query(32'sh8000_0000, 32'sh7FFF_FFFF);
    query(32'sh7FFF_FFFF, 32'sh8000_0000);
    query(0, 0);

    // Unit cells on a 16 x 16 grid, corners at the value extremes
    apply_setting(0, 0, 32'd65536, 9'd16, 9'd16, 1'b1);
    write_cell(0, 16'hFFFF);
    write_cell(1, 16'h0000);
    write_cell(16, 16'h0000);
    write_cell(17, 16'hFFFF);
    write_cell(16'hFFFF, 16'hFFFF);
    query(0, 0);
    query(32'sh8000, 32'sh8000);
    query(32'sh000E_FFFF, 32'sh000E_FFFF);
    query(32'sh000F_0000, 0);
    query(0, 32'sh000F_0000);
    query(-1, 0);
    query(0, -1);
    query(32'sh7FFF_FFFF, 32'sh8000_0000);

    // Steepest scale: gradients saturate both ways
    apply_setting(0, 0, 32'hFFFF_FFFF, 9'd16, 9'd16, 1'b1);
    query(1, 1);
    query(32'sh4000, 1);
    query(0, 0);

    // Zero scale: every position falls on cell 0
    apply_setting(0, 0, 32'd0, 9'd16, 9'd16, 1'b1);
    query(32'sh8000_0000, 32'sh7FFF_FFFF);
    query(32'sh1234_5678, -5);

    // Unused register indexes must change nothing
    settle();
    write_reg(REG_SPARE_6, $urandom);
    write_reg(REG_SPARE_7, $urandom);
    cfg_if.valid <= 1'b0;
    query(32'sh0001_0000, 32'sh0002_0000);

    // Random phases over a range of settings
    apply_setting(0, 0, 32'd65536, 9'd16, 9'd16, 1'b1);
    random_items(30);
    apply_setting(32'sh8000_0000, 32'sh7FFF_FFFF, 32'd1, 9'd2, 9'd2, 1'b1);
    random_items(30);
    apply_setting($urandom_range(0, 65535), -$urandom_range(0, 65535), 32'hFFFF_FFFF,
                  9'd128, 9'd2, 1'b1);
    random_items(30);
    apply_setting($urandom, $urandom, 32'd0, 9'd2, 9'd128, 1'b1);
    random_items(30);
    apply_setting($urandom, $urandom, $urandom, 9'd511, 9'd1, 1'b1);
    random_items(20);
    apply_setting($urandom, $urandom, $urandom, 9'd256, 9'd256, 1'b0);
    random_items(20);
    apply_setting($urandom, $urandom, $urandom, 9'd0, 9'd2, 1'b1);
    random_items(15);
    for (int p = 0; p < 4; p++) begin
      apply_setting($signed($urandom) >>> 1, $signed($urandom) >>> 1,
                    $urandom_range(4096, 1 << 20), 9'($urandom_range(2, 16)),
                    9'($urandom_range(2, 16)), 1'b1);
      quiet = (p == 1);
      random_items(35);
    end
    quiet = 1'b0;

    settle();
    if (fail_cnt == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/bdgl_pkg.sv
rtl/core/bdgl_intf.sv
rtl/core/bdgl_ram.sv
rtl/core/bilinear_distance_gradient_lookup.sv
tb/bdgl_checker.sv
tb/testbench.sv
